// File: src/fpcfb_pkg.sv
package fpcfb_pkg;

   // Data widths
   localparam int WORD_W  = 32;
   localparam int BYTE_W  = 8;
   localparam int IDX_W   = 6;
   localparam int CSR_IDX_W = 2;

   // Frame geometry
   localparam int FRAME_LEN = 62;
   localparam logic [IDX_W-1:0] ADDR_POS     = IDX_W'(7);
   localparam logic [IDX_W-1:0] ACCESS_POS   = IDX_W'(15);
   localparam logic [IDX_W-1:0] FWD_POS      = IDX_W'(21);
   localparam logic [IDX_W-1:0] REV_POS      = IDX_W'(28);
   localparam logic [IDX_W-1:0] SUM_FIRST    = IDX_W'(4);
   localparam logic [IDX_W-1:0] SUM_LAST     = IDX_W'(59);
   localparam logic [IDX_W-1:0] CHECKSUM_POS = IDX_W'(60);
   localparam logic [IDX_W-1:0] LAST_POS     = IDX_W'(FRAME_LEN - 1);

   // Counter and threshold constants
   localparam logic [WORD_W-1:0] DEFAULT_THRESHOLD = WORD_W'(100000);
   localparam logic [WORD_W-1:0] BCD_LIMIT         = WORD_W'(99999999);
   localparam logic [WORD_W-1:0] DEFAULT_ADDRESS   = 32'h1234_5678;

   // Double-dabble sequencing: one input bit per step
   localparam int CONV_STEPS = WORD_W;
   localparam int STEP_W     = $clog2(CONV_STEPS);
   localparam int DIGITS     = WORD_W / 4;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_ADDRESS   = 2'd1
   } csr_index_type;

   // Request kinds
   typedef enum logic [1:0] {
      KIND_FORWARD = 2'd0,
      KIND_REVERSE = 2'd1,
      KIND_READ    = 2'd2,
      KIND_UNUSED  = 2'd3
   } kind_type;

   // Fixed frame bytes; dynamic positions hold zero here
   localparam logic [BYTE_W-1:0] FRAME_TEMPLATE [FRAME_LEN] = '{
      8'h68, 8'h38, 8'h38, 8'h68, 8'h08, 8'h90, 8'h72, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h33, 8'h78, 8'h01, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h0C, 8'h13, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h8C, 8'h10, 8'h13, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h0C, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0C, 8'h26, 8'h00, 8'h00,
      8'h00, 8'h00,
      8'h0B, 8'h59, 8'h00, 8'h00, 8'h00, 8'h04, 8'h6D, 8'h00, 8'h00, 8'h00,
      8'h00,
      8'h02, 8'hFD, 8'h17, 8'h00, 8'h00,
      8'h00, 8'h16
   };

endpackage

// File: src/flow_pulse_counter_frame_builder_top.sv
// Channel   Direction  Ports                               Transaction
// req       in         req_valid/ready, kind, high_time    pulse or read request
// rsp       out        rsp_valid/ready, frame_byte, last   one frame byte
// csr       in         csr_valid/ready, index, data        register write
//
// A read runs two passes of the shared binary-to-BCD shifter (forward, then
// reverse counter), then sends 62 bytes at one per cycle from the output
// register while rsp_ready stays high. req_ready is low from a read until
// its last byte is loaded; rsp stalls hold the byte sequencer. csr writes
// are always taken. Reset is synchronous.
module flow_pulse_counter_frame_builder_top
   import fpcfb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_kind,
   input  logic [WORD_W-1:0]    req_high_time,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BYTE_W-1:0]    rsp_frame_byte,
   output logic                 rsp_last_byte,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_data
);

   typedef enum logic [3:0] {
      S_IDLE     = 4'b0001,
      S_CONV_FWD = 4'b0010,
      S_CONV_REV = 4'b0100,
      S_SEND     = 4'b1000
   } state_type;

   state_type         state_ff,    state_in;
   logic [WORD_W-1:0] thresh_ff,   thresh_in;
   logic [WORD_W-1:0] address_ff,  address_in;
   logic [WORD_W-1:0] fwd_cnt_ff,  fwd_cnt_in;
   logic [WORD_W-1:0] rev_cnt_ff,  rev_cnt_in;
   logic [BYTE_W-1:0] seq_ff,      seq_in;
   logic [WORD_W-1:0] fwd_enc_ff,  fwd_enc_in;
   logic [WORD_W-1:0] rev_enc_ff,  rev_enc_in;
   logic [IDX_W-1:0]  idx_ff,      idx_in;
   logic [BYTE_W-1:0] sum_ff,      sum_in;
   logic              out_vld_ff,  out_vld_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   logic              req_fire;
   logic              csr_fire;
   logic [WORD_W-1:0] eff_thresh;
   logic              pulse_counts;
   logic              conv_start;
   logic [WORD_W-1:0] conv_value;
   logic              conv_done;
   logic [WORD_W-1:0] conv_bcd;
   logic              load;
   logic [BYTE_W-1:0] cur_byte;
   logic [1:0]        sel;
   kind_type          kind;

   assign kind       = kind_type'(req_kind);
   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign eff_thresh = (thresh_ff == '0) ? DEFAULT_THRESHOLD : thresh_ff;
   assign pulse_counts = (req_high_time > eff_thresh);

   // Shared shifter: forward counter on the read, reverse when forward is done
   assign conv_start = (req_fire && kind == KIND_READ) ||
                       (state_ff == S_CONV_FWD && conv_done);
   assign conv_value = (state_ff == S_IDLE) ? fwd_cnt_ff : rev_cnt_ff;

   fpcfb_bcd_conv u_bcd (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .value (conv_value),
      .done  (conv_done),
      .bcd   (conv_bcd)
   );

   // Select the frame byte at the current index
   always_comb begin
      cur_byte = FRAME_TEMPLATE[idx_ff];
      sel      = 2'b00;
      if (idx_ff >= ADDR_POS && idx_ff < ADDR_POS + IDX_W'(4)) begin
         sel      = 2'(idx_ff - ADDR_POS);
         cur_byte = address_ff[8*sel +: 8];
      end else if (idx_ff == ACCESS_POS) begin
         cur_byte = seq_ff;
      end else if (idx_ff >= FWD_POS && idx_ff < FWD_POS + IDX_W'(4)) begin
         sel      = 2'(idx_ff - FWD_POS);
         cur_byte = fwd_enc_ff[8*sel +: 8];
      end else if (idx_ff >= REV_POS && idx_ff < REV_POS + IDX_W'(4)) begin
         sel      = 2'(idx_ff - REV_POS);
         cur_byte = rev_enc_ff[8*sel +: 8];
      end else if (idx_ff == CHECKSUM_POS) begin
         cur_byte = sum_ff;
      end
   end

   assign load = (state_ff == S_SEND) && (!out_vld_ff || rsp_ready);

   // Sequencer, counters and configuration
   always_comb begin
      state_in    = state_ff;
      thresh_in   = thresh_ff;
      address_in  = address_ff;
      fwd_cnt_in  = fwd_cnt_ff;
      rev_cnt_in  = rev_cnt_ff;
      seq_in      = seq_ff;
      fwd_enc_in  = fwd_enc_ff;
      rev_enc_in  = rev_enc_ff;
      idx_in      = idx_ff;
      sum_in      = sum_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      out_vld_in  = out_vld_ff && !rsp_ready;

      if (csr_fire) begin
         unique case (csr_index)
            CSR_THRESHOLD: thresh_in  = csr_data;
            CSR_ADDRESS:   address_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (kind)
                  KIND_FORWARD: if (pulse_counts) fwd_cnt_in = fwd_cnt_ff + 1'b1;
                  KIND_REVERSE: if (pulse_counts) rev_cnt_in = rev_cnt_ff + 1'b1;
                  KIND_READ: begin
                     seq_in   = seq_ff + 1'b1;
                     state_in = S_CONV_FWD;
                  end
                  default: ;
               endcase
            end
         end
         S_CONV_FWD: begin
            if (conv_done) begin
               fwd_enc_in = (fwd_cnt_ff <= BCD_LIMIT) ? conv_bcd : fwd_cnt_ff;
               state_in   = S_CONV_REV;
            end
         end
         S_CONV_REV: begin
            if (conv_done) begin
               rev_enc_in = (rev_cnt_ff <= BCD_LIMIT) ? conv_bcd : rev_cnt_ff;
               idx_in     = '0;
               sum_in     = '0;
               state_in   = S_SEND;
            end
         end
         S_SEND: begin
            // Load the next byte when the output register is free
            if (load) begin
               out_vld_in  = 1'b1;
               out_byte_in = cur_byte;
               out_last_in = (idx_ff == LAST_POS);
               if (idx_ff >= SUM_FIRST && idx_ff <= SUM_LAST) begin
                  sum_in = sum_ff + cur_byte;
               end
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LAST_POS) begin
                  idx_in   = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         thresh_ff  <= DEFAULT_THRESHOLD;
         address_ff <= DEFAULT_ADDRESS;
         fwd_cnt_ff <= '0;
         rev_cnt_ff <= '0;
         seq_ff     <= '0;
         idx_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         thresh_ff  <= thresh_in;
         address_ff <= address_in;
         fwd_cnt_ff <= fwd_cnt_in;
         rev_cnt_ff <= rev_cnt_in;
         seq_ff     <= seq_in;
         idx_ff     <= idx_in;
         out_vld_ff <= out_vld_in;
      end
      fwd_enc_ff  <= fwd_enc_in;
      rev_enc_ff  <= rev_enc_in;
      sum_ff      <= sum_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_frame_byte = out_byte_ff;
   assign rsp_last_byte  = out_last_ff;

endmodule

// File: src/fpcfb_bcd_conv.sv
module fpcfb_bcd_conv
   import fpcfb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] value,
   output logic              done,
   output logic [WORD_W-1:0] bcd
);

   logic [WORD_W-1:0] bin_ff,   bin_in;
   logic [WORD_W-1:0] bcd_ff,   bcd_in;
   logic [STEP_W-1:0] step_ff,  step_in;
   logic              busy_ff,  busy_in;
   logic              done_ff,  done_in;
   logic [WORD_W-1:0] adj;

   // Add three to every digit of five or more before the shift
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   // Load on start, then shift one binary bit into the digits per cycle
   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = value;
         bcd_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in  = {adj[WORD_W-2:0], bin_ff[WORD_W-1]};
         bin_in  = {bin_ff[WORD_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(CONV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule
